@@ src/mcr_pkg.sv @@
package mcr_pkg;

  localparam int unsigned CoordW = 10;
  localparam int unsigned RadW   = 9;
  localparam int unsigned PixW   = 12;
  localparam int unsigned DecW   = 12;

  // job queue between front and back end
  localparam int unsigned FifoDepth = 2;
  localparam int unsigned FifoAw    = $clog2(FifoDepth);
  localparam int unsigned FifoCntW  = $clog2(FifoDepth + 1);

  // pixel index within one job
  localparam int unsigned IdxW = 3;

  typedef enum logic {
    ModeStart = 1'b0,
    ModeStep  = 1'b1
  } mode_e;

  localparam logic [IdxW-1:0] StartLastIdx = IdxW'(3);
  localparam logic [IdxW-1:0] StepLastIdx  = IdxW'(7);

  // one unit of work for the back end: center, current offsets, kind
  typedef struct packed {
    logic [CoordW-1:0] cx;
    logic [CoordW-1:0] cy;
    logic [CoordW-1:0] ox;
    logic [CoordW-1:0] oy;
    logic              step;
    logic              fin;
  } job_t;

endpackage

@@ src/mcr_in_if.sv @@
interface mcr_in_if;
  import mcr_pkg::*;

  logic              valid;
  logic              ready;
  logic              mode;
  logic [CoordW-1:0] center_x;
  logic [CoordW-1:0] center_y;
  logic [RadW-1:0]   radius;

  modport source (output valid, mode, center_x, center_y, radius, input ready);
  modport sink   (input valid, mode, center_x, center_y, radius, output ready);
endinterface

@@ src/mcr_out_if.sv @@
interface mcr_out_if;
  import mcr_pkg::*;

  logic                   valid;
  logic                   ready;
  logic signed [PixW-1:0] pixel_x;
  logic signed [PixW-1:0] pixel_y;
  logic                   last;
  logic                   finished;

  modport source (output valid, pixel_x, pixel_y, last, finished, input ready);
  modport sink   (input valid, pixel_x, pixel_y, last, finished, output ready);
endinterface

@@ src/mcr_front.sv @@
module mcr_front (
  input  logic          clk_i,
  input  logic          rst_ni,
  mcr_in_if.sink        in_i,
  output logic          push_valid_o,
  output mcr_pkg::job_t push_job_o,
  input  logic          push_ready_i
);
  import mcr_pkg::*;

  logic [CoordW-1:0] ctr_x_q, ctr_x_d;
  logic [CoordW-1:0] ctr_y_q, ctr_y_d;
  logic [CoordW-1:0] off_x_q, off_x_d;
  logic [CoordW-1:0] off_y_q, off_y_d;
  logic [DecW-1:0]   dec_q, dec_d;
  logic              done_q, done_d;

  logic              accept;
  logic              is_start;
  logic [DecW-1:0]   two_x;
  logic [DecW-1:0]   diff;
  logic [DecW-1:0]   dec_step;
  logic [CoordW-1:0] x_step;
  logic [CoordW-1:0] y_step;
  logic              done_step;

  assign in_i.ready = push_ready_i;
  assign accept     = in_i.valid && push_ready_i;
  assign is_start   = (in_i.mode == ModeStart);

  // one midpoint step
  always_comb begin
    two_x = {1'b0, off_x_q, 1'b0};
    diff  = {2'b00, off_x_q} - {2'b00, off_y_q};
    if (dec_q[DecW-1]) begin
      dec_step = dec_q + two_x + DecW'(3);
      y_step   = off_y_q;
    end else begin
      dec_step = dec_q + {diff[DecW-2:0], 1'b0} + DecW'(5);
      // zero radius: y saturates at 0
      y_step   = (off_y_q != '0) ? off_y_q - CoordW'(1) : off_y_q;
    end
    x_step    = off_x_q + CoordW'(1);
    done_step = x_step > y_step;
  end

  always_comb begin
    ctr_x_d = ctr_x_q;
    ctr_y_d = ctr_y_q;
    off_x_d = off_x_q;
    off_y_d = off_y_q;
    dec_d   = dec_q;
    done_d  = done_q;
    push_valid_o = 1'b0;
    push_job_o   = '{cx: ctr_x_q, cy: ctr_y_q, ox: x_step, oy: y_step,
                     step: 1'b1, fin: done_step};
    if (accept) begin
      if (is_start) begin
        ctr_x_d = in_i.center_x;
        ctr_y_d = in_i.center_y;
        off_x_d = '0;
        off_y_d = CoordW'(in_i.radius);
        dec_d   = DecW'(1) - DecW'(in_i.radius);
        done_d  = 1'b0;
        push_valid_o = 1'b1;
        push_job_o   = '{cx: in_i.center_x, cy: in_i.center_y, ox: '0,
                         oy: CoordW'(in_i.radius), step: 1'b0, fin: 1'b0};
      end else if (!done_q) begin
        off_x_d = x_step;
        off_y_d = y_step;
        dec_d   = dec_step;
        done_d  = done_step;
        push_valid_o = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctr_x_q <= '0;
      ctr_y_q <= '0;
      off_x_q <= '0;
      off_y_q <= '0;
      dec_q   <= '0;
      done_q  <= 1'b1;
    end else begin
      ctr_x_q <= ctr_x_d;
      ctr_y_q <= ctr_y_d;
      off_x_q <= off_x_d;
      off_y_q <= off_y_d;
      dec_q   <= dec_d;
      done_q  <= done_d;
    end
  end

  a_start_arms: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && is_start) |=> !done_q)
    else $error("start transfer did not arm the circle");

  a_idle_step_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && !is_start && done_q) |-> !push_valid_o)
    else $error("step with no active circle produced a job");
endmodule

@@ src/mcr_fifo.sv @@
module mcr_fifo (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_valid_i,
  input  mcr_pkg::job_t push_job_i,
  output logic          push_ready_o,
  output logic          pop_valid_o,
  output mcr_pkg::job_t pop_job_o,
  input  logic          pop_i
);
  import mcr_pkg::*;

  job_t                mem_q [FifoDepth];
  logic [FifoAw-1:0]   wr_ptr_q, rd_ptr_q;
  logic [FifoCntW-1:0] cnt_q;
  logic                do_push, do_pop;

  assign push_ready_o = (cnt_q != FifoCntW'(FifoDepth));
  assign pop_valid_o  = (cnt_q != '0);
  assign pop_job_o    = mem_q[rd_ptr_q];
  assign do_push      = push_valid_i && push_ready_o;
  assign do_pop       = pop_i && pop_valid_o;

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_job_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= wr_ptr_q + FifoAw'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= rd_ptr_q + FifoAw'(1);
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + FifoCntW'(1);
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - FifoCntW'(1);
      end
    end
  end

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= FifoCntW'(FifoDepth))
    else $error("job queue count beyond depth");
endmodule

@@ src/mcr_back.sv @@
module mcr_back (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          job_valid_i,
  input  mcr_pkg::job_t job_i,
  output logic          pop_o,
  mcr_out_if.source     out_o
);
  import mcr_pkg::*;

  logic [IdxW-1:0]        idx_q, idx_d;
  logic                   out_valid_q, out_valid_d;
  logic signed [PixW-1:0] px_q, py_q;
  logic                   last_q, fin_q;

  logic                   load;
  logic                   is_last;
  logic signed [PixW-1:0] u, v, dx, dy;

  assign u = $signed({2'b00, job_i.ox});
  assign v = $signed({2'b00, job_i.oy});

  // offset of the current pixel from the center
  always_comb begin
    dx = '0;
    dy = '0;
    if (job_i.step) begin
      unique case (idx_q)
        3'd0: begin dx =  u; dy =  v; end
        3'd1: begin dx = -u; dy =  v; end
        3'd2: begin dx =  u; dy = -v; end
        3'd3: begin dx = -u; dy = -v; end
        3'd4: begin dx =  v; dy =  u; end
        3'd5: begin dx = -v; dy =  u; end
        3'd6: begin dx =  v; dy = -u; end
        3'd7: begin dx = -v; dy = -u; end
        default: begin dx = '0; dy = '0; end
      endcase
    end else begin
      unique case (idx_q)
        3'd0: begin dx = '0; dy =  v;  end
        3'd1: begin dx = '0; dy = -v;  end
        3'd2: begin dx = -v; dy = '0;  end
        default: begin dx = v; dy = '0; end
      endcase
    end
  end

  assign is_last = job_i.step ? (idx_q == StepLastIdx) : (idx_q == StartLastIdx);
  assign load    = job_valid_i && (!out_valid_q || out_o.ready);
  assign pop_o   = load && is_last;

  always_comb begin
    idx_d       = idx_q;
    out_valid_d = out_valid_q;
    if (load) begin
      idx_d       = is_last ? '0 : idx_q + IdxW'(1);
      out_valid_d = 1'b1;
    end else if (out_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      idx_q       <= idx_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      px_q   <= $signed({2'b00, job_i.cx}) + dx;
      py_q   <= $signed({2'b00, job_i.cy}) + dy;
      last_q <= is_last;
      fin_q  <= job_i.fin;
    end
  end

  assign out_o.valid    = out_valid_q;
  assign out_o.pixel_x  = px_q;
  assign out_o.pixel_y  = py_q;
  assign out_o.last     = last_q;
  assign out_o.finished = fin_q;

  a_start_idx: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (job_valid_i && !job_i.step) |-> (idx_q <= StartLastIdx))
    else $error("pixel index past end of start job");

  a_pop_on_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_o |=> (idx_q == '0))
    else $error("pixel index not rewound after job");
endmodule

@@ src/midpoint_circle_rasterizer.sv @@
// Midpoint circle rasterizer. A start transfer (mode 0) loads center and
// radius and yields the four axis pixels (top, bottom, left, right of the
// center), the fourth marked last. Each step transfer (mode 1) advances the
// circle by one column and yields the eight octant-symmetric pixels, the
// eighth marked last; finished is set on all eight once x has passed y.
// A step with no active circle (after reset or after the circle finished)
// is taken and yields nothing. Pixel coordinates are 12-bit two's
// complement and may lie off screen. Rate: the output runs at one pixel per
// cycle while the sink is ready; the single output register of the back end
// sets that rate. The front end updates the circle state in the cycle of the
// transfer and queues a job in a two-entry queue, so input and output stall
// independently; a no-op step queues no job.
module midpoint_circle_rasterizer (
  input  logic      clk_i,
  input  logic      rst_ni,
  mcr_in_if.sink    in_i,
  mcr_out_if.source out_o
);
  import mcr_pkg::*;

  // front end -> queue
  logic push_valid, push_ready;
  job_t push_job;

  // queue -> back end
  logic head_valid, head_pop;
  job_t head_job;

  // Circle state and the decision update live here.
  mcr_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_i         (in_i),
    .push_valid_o (push_valid),
    .push_job_o   (push_job),
    .push_ready_i (push_ready)
  );

  // Short job queue decoupling state update from pixel output.
  mcr_fifo u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_job_i   (push_job),
    .push_ready_o (push_ready),
    .pop_valid_o  (head_valid),
    .pop_job_o    (head_job),
    .pop_i        (head_pop)
  );

  // Walks each job's pixel list, one pixel per transfer.
  mcr_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_valid_i (head_valid),
    .job_i       (head_job),
    .pop_o       (head_pop),
    .out_o       (out_o)
  );
endmodule

@@ verif/midpoint_circle_rasterizer_tb.sv @@
module midpoint_circle_rasterizer_tb;
  import mcr_pkg::*;

  // Stimulus stops once this many random transfers have produced pixels.
  localparam int unsigned RandomItems   = 430;
  localparam int unsigned TimeoutCycles = 400_000;
  // Drain time after the last expected pixel shows up.
  localparam int unsigned DrainCycles   = 24;

  // One expected pixel on the output channel.
  typedef struct {
    logic signed [PixW-1:0] px;
    logic signed [PixW-1:0] py;
    logic                   last;
    logic                   fin;
  } pixel_t;

  // Shadow copy of the circle state plus the queue of pixels it predicts.
  class circle_tracker;
    logic [CoordW-1:0]      ctr_x;
    logic [CoordW-1:0]      ctr_y;
    logic [CoordW-1:0]      off_x;
    logic [CoordW-1:0]      off_y;
    logic signed [DecW-1:0] decision;
    bit                     no_circle;
    pixel_t                 pending[$];
    int unsigned            errors;

    function new();
      ctr_x     = '0;
      ctr_y     = '0;
      off_x     = '0;
      off_y     = '0;
      decision  = '0;
      no_circle = 1'b1;
      errors    = 0;
    endfunction

    function void push_pixel(int px, int py, bit last, bit fin);
      pixel_t p;
      p.px   = PixW'(px);
      p.py   = PixW'(py);
      p.last = last;
      p.fin  = fin;
      pending.push_back(p);
    endfunction

    // Note an accepted input transfer; returns the number of pixels it yields.
    function int take_item(mode_e mode, logic [CoordW-1:0] cx, logic [CoordW-1:0] cy,
                           logic [RadW-1:0] r);
      int x;
      int y;
      int d;
      int ix;
      int iy;
      bit fin;
      if (mode == ModeStart) begin
        ctr_x     = cx;
        ctr_y     = cy;
        off_x     = '0;
        off_y     = CoordW'(r);
        decision  = DecW'(1 - int'(r));
        no_circle = 1'b0;
        ix = int'(cx);
        iy = int'(cy);
        push_pixel(ix, iy + int'(r), 0, 0);
        push_pixel(ix, iy - int'(r), 0, 0);
        push_pixel(ix - int'(r), iy, 0, 0);
        push_pixel(ix + int'(r), iy, 1, 0);
        return 4;
      end
      if (no_circle) return 0;
      x = int'(off_x);
      y = int'(off_y);
      d = int'(decision);
      if (d < 0) begin
        d += 2 * x + 3;
      end else begin
        d += 2 * (x - y) + 5;
        if (y > 0) y--;  // zero radius: y sticks at 0
      end
      x++;
      off_x    = CoordW'(x);
      off_y    = CoordW'(y);
      decision = DecW'(d);
      x = int'(off_x);
      y = int'(off_y);
      no_circle = (x > y);
      fin = no_circle;
      ix = int'(ctr_x);
      iy = int'(ctr_y);
      push_pixel(ix + x, iy + y, 0, fin);
      push_pixel(ix - x, iy + y, 0, fin);
      push_pixel(ix + x, iy - y, 0, fin);
      push_pixel(ix - x, iy - y, 0, fin);
      push_pixel(ix + y, iy + x, 0, fin);
      push_pixel(ix - y, iy + x, 0, fin);
      push_pixel(ix + y, iy - x, 0, fin);
      push_pixel(ix - y, iy - x, 1, fin);
      return 8;
    endfunction

    // Compare one accepted output transfer with the oldest expected pixel.
    function void check_pixel(logic signed [PixW-1:0] px, logic signed [PixW-1:0] py,
                              logic last, logic fin);
      pixel_t e;
      if (pending.size() == 0) begin
        $error("unexpected pixel (%0d, %0d) with nothing pending", px, py);
        errors++;
        return;
      end
      e = pending.pop_front();
      if (px !== e.px) begin
        $error("pixel_x expected %0d actual %0d", e.px, px);
        errors++;
      end
      if (py !== e.py) begin
        $error("pixel_y expected %0d actual %0d", e.py, py);
        errors++;
      end
      if (last !== e.last) begin
        $error("last expected %0b actual %0b", e.last, last);
        errors++;
      end
      if (fin !== e.fin) begin
        $error("finished expected %0b actual %0b", e.fin, fin);
        errors++;
      end
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni;

  mcr_in_if  in_if ();
  mcr_out_if out_if ();

  midpoint_circle_rasterizer u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  circle_tracker tracker;
  int unsigned   drawn_items;
  // Calm stretches: while set, that side never idles.
  bit            src_calm;
  bit            snk_calm;

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // Drive one input transfer after a random gap. valid is only lowered when a
  // gap is taken, so back-to-back transfers keep it high.
  task automatic send_item(input mode_e mode, input logic [CoordW-1:0] cx,
                           input logic [CoordW-1:0] cy, input logic [RadW-1:0] r);
    int unsigned gap;
    gap = src_calm ? 0 : $urandom_range(0, 13);
    if (gap != 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_if.valid    <= 1'b1;
    in_if.mode     <= mode;
    in_if.center_x <= cx;
    in_if.center_y <= cy;
    in_if.radius   <= r;
    do @(posedge clk_i); while (!in_if.ready);
    // steps with no active circle yield nothing and don't count
    if (tracker.take_item(mode, cx, cy, r) != 0) drawn_items++;
    if ($urandom_range(0, 39) == 0) src_calm = !src_calm;
  endtask

  // Step with junk in the fields that a step ignores.
  task automatic send_step();
    send_item(ModeStep, CoordW'($urandom()), CoordW'($urandom()), RadW'($urandom()));
  endtask

  // Step until x passes y, then a few no-op steps on the dead circle.
  task automatic finish_circle(input int unsigned extra);
    while (!tracker.no_circle) send_step();
    repeat (extra) send_step();
  endtask

  // Output side: random stall before each pixel, then check the transfer.
  initial begin
    int unsigned stall;
    out_if.ready <= 1'b0;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      stall = snk_calm ? 0 : $urandom_range(0, 13);
      if (stall != 0) begin
        out_if.ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      out_if.ready <= 1'b1;
      do @(posedge clk_i); while (!out_if.valid);
      tracker.check_pixel(out_if.pixel_x, out_if.pixel_y, out_if.last, out_if.finished);
      if ($urandom_range(0, 59) == 0) snk_calm = !snk_calm;
    end
  end

  initial begin
    int unsigned pick;
    int unsigned steps;
    logic [RadW-1:0] r;
    tracker        = new();
    drawn_items    = 0;
    src_calm       = 1'b0;
    snk_calm       = 1'b0;
    rst_ni         <= 1'b0;
    in_if.valid    <= 1'b0;
    in_if.mode     <= ModeStart;
    in_if.center_x <= '0;
    in_if.center_y <= '0;
    in_if.radius   <= '0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // --- directed part ---
    // step right after reset: no circle active, nothing comes out
    send_step();
    // zero radius: four pixels on the center, then one step that ends it
    send_item(ModeStart, '0, '0, '0);
    send_step();
    send_step();  // dead circle
    // largest center and radius: coordinates past the screen edge
    send_item(ModeStart, '1, '1, '1);
    send_step();
    send_step();
    // smallest center, largest radius: negative coordinates
    send_item(ModeStart, '0, '0, '1);
    send_step();
    send_step();
    // restart in the middle of a circle
    send_item(ModeStart, CoordW'(1023), CoordW'(0), RadW'(1));
    finish_circle(1);
    send_item(ModeStart, CoordW'(0), CoordW'(1023), RadW'(5));
    finish_circle(1);
    send_item(ModeStart, CoordW'(512), CoordW'(511), RadW'(256));
    send_step();

    // --- random part ---
    // Mostly whole circles of small radius; some aborted by a new start,
    // large radii only run a few steps.
    drawn_items = 0;
    while (drawn_items < RandomItems) begin
      pick = $urandom_range(0, 99);
      if (pick < 60)      r = RadW'($urandom_range(0, 24));
      else if (pick < 90) r = RadW'($urandom_range(25, 120));
      else                r = RadW'($urandom_range(121, 511));
      send_item(ModeStart, CoordW'($urandom()), CoordW'($urandom()), r);
      if (r > 120 || $urandom_range(0, 9) < 2) begin
        // broken sequence: a handful of steps, then the next start cuts in
        steps = $urandom_range(0, 30);
        while (steps != 0 && drawn_items < RandomItems) begin
          send_step();
          steps--;
        end
      end else begin
        while (!tracker.no_circle && drawn_items < RandomItems) send_step();
        if ($urandom_range(0, 3) == 0) send_step();
      end
    end

    in_if.valid <= 1'b0;
    while (tracker.pending.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (tracker.errors == 0 && tracker.pending.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  // hang guard
  initial begin
    #(TimeoutCycles * 20);
    $display("Verification failed");
    $finish;
  end

endmodule

@@ filelist.f @@
src/mcr_pkg.sv
src/mcr_in_if.sv
src/mcr_out_if.sv
src/mcr_front.sv
src/mcr_fifo.sv
src/mcr_back.sv
src/midpoint_circle_rasterizer.sv
verif/midpoint_circle_rasterizer_tb.sv
